@@ hdl/substring_match_counter_macros.svh @@
// ----------------------------------------------------------------------------
// substring_match_counter_macros
// Assertion macros shared by the substring match counter.
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_MATCH_COUNTER_MACROS_SVH
`define SUBSTRING_MATCH_COUNTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SMC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/smc_pkg.sv @@
// ----------------------------------------------------------------------------
// smc_pkg
// Types and constants of the substring match counter.
// ----------------------------------------------------------------------------
package smc_pkg;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 64;
    localparam int PAT_WORDS = 4;
    localparam int PAT_BYTES = 32;
    localparam int WORD_BYTES = WORD_W / BYTE_W;
    localparam int LEN_W     = 6;
    localparam int LEN_CMP_W = LEN_W + 1;
    localparam int CNT_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WORD_0,
        CFG_WORD_1,
        CFG_WORD_2,
        CFG_WORD_3,
        CFG_LENGTH
    } t_cfg_index;

    typedef struct packed {
        logic              step;
        logic              clear;
        logic [BYTE_W-1:0] text_byte;
    } t_cell_ctrl;

    typedef struct packed {
        logic             match_here;
        logic [CNT_W-1:0] match_count;
        logic             found;
        logic             text_done;
    } t_result;

endpackage

@@ hdl/substring_match_counter.sv @@
// ----------------------------------------------------------------------------
// substring_match_counter
// Exact substring search over a byte stream with a row of shift-and cells,
// a saturating occurrence count and a found flag per text.
//
//   channel  direction  signals
//   in       sink       i_valid, o_ready, i_text_byte, i_end_of_text
//   out      source     o_valid, i_ready, o_match_here, o_match_count,
//                       o_found, o_text_done
//   cfg      sink       i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data
//
// One byte per cycle while the output queue has room; each result is registered
// in the output queue. Every cell updates its prefix bit in the transfer cycle,
// so a result waits only in the two-entry output queue, which keeps input open.
// Input stalls only when both queue entries are held by the output side.
// Synchronous active-low reset clears pattern, length, cells and counters.
// ----------------------------------------------------------------------------
module substring_match_counter
    import smc_pkg::*;
#(
    parameter int MAX_PATTERN = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [BYTE_W-1:0]    i_text_byte,
    input  logic                 i_end_of_text,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_match_here,
    output logic [CNT_W-1:0]     o_match_count,
    output logic                 o_found,
    output logic                 o_text_done,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

`include "substring_match_counter_macros.svh"

    logic [PAT_WORDS-1:0][WORD_W-1:0] r_pattern;
    logic [LEN_W-1:0]                 r_len;
    logic [CNT_W-1:0]                 r_count;
    logic [CNT_W-1:0]                 n_count;
    logic                             r_found;
    logic                             n_found;
    logic [LEN_CMP_W-1:0]             w_len_eff;
    logic [MAX_PATTERN-1:0]           w_bits;
    logic [MAX_PATTERN-1:0]           w_next;
    logic [MAX_PATTERN-1:0]           w_last_sel;
    logic                             w_accept;
    logic                             w_hit;
    t_cell_ctrl                       w_ctrl;
    t_result                          w_result;
    t_result                          w_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_len     <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_WORD_0: r_pattern[0] <= i_cfg_data;
                CFG_WORD_1: r_pattern[1] <= i_cfg_data;
                CFG_WORD_2: r_pattern[2] <= i_cfg_data;
                CFG_WORD_3: r_pattern[3] <= i_cfg_data;
                CFG_LENGTH: r_len        <= i_cfg_data[LEN_W-1:0];
                default:    ;
            endcase
        end
    end

    assign w_len_eff = (LEN_CMP_W'(r_len) > LEN_CMP_W'(MAX_PATTERN))
                     ? LEN_CMP_W'(MAX_PATTERN) : LEN_CMP_W'(r_len);

    assign w_accept         = i_valid && o_ready;
    assign w_ctrl.step      = w_accept;
    assign w_ctrl.clear     = i_end_of_text;
    assign w_ctrl.text_byte = i_text_byte;

    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
        logic              w_prev;
        logic [BYTE_W-1:0] w_pat_byte;
        logic              w_enable;

        if (i == 0) begin : g_head
            assign w_prev = 1'b1;
        end else begin : g_link
            assign w_prev = w_bits[i-1];
        end

        if (i < PAT_BYTES) begin : g_held
            assign w_pat_byte = r_pattern[i / WORD_BYTES][(i % WORD_BYTES) * BYTE_W +: BYTE_W];
        end else begin : g_blank
            assign w_pat_byte = '0;
        end

        assign w_enable      = LEN_CMP_W'(r_len) > LEN_CMP_W'(i);
        assign w_last_sel[i] = (w_len_eff == LEN_CMP_W'(i + 1));

        smc_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctrl         (w_ctrl),
            .i_prev         (w_prev),
            .i_enable       (w_enable),
            .i_pattern_byte (w_pat_byte),
            .o_bit          (w_bits[i]),
            .o_next         (w_next[i])
        );
    end

    assign w_hit = |(w_next & w_last_sel);

    always_comb begin
        n_count = r_count;
        if (w_hit && (r_count != CNT_MAX)) begin
            n_count = r_count + CNT_W'(1);
        end
        n_found = r_found || w_hit;
        w_result.match_here  = w_hit;
        w_result.match_count = n_count;
        w_result.found       = n_found;
        w_result.text_done   = i_end_of_text;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_found <= 1'b0;
        end else if (w_accept) begin
            if (i_end_of_text) begin
                r_count <= '0;
                r_found <= 1'b0;
            end else begin
                r_count <= n_count;
                r_found <= n_found;
            end
        end
    end

    smc_out_queue u_out_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_valid),
        .o_push_ready (o_ready),
        .i_data       (w_result),
        .o_pop_valid  (o_valid),
        .i_pop_ready  (i_ready),
        .o_data       (w_out)
    );

    assign o_match_here  = w_out.match_here;
    assign o_match_count = w_out.match_count;
    assign o_found       = w_out.found;
    assign o_text_done   = w_out.text_done;

    `SMC_ASSERT_NOW(a_hit_counted, i_clk, i_rst_n, o_valid && o_match_here, o_found && (o_match_count != '0), "match reported without found flag or count")
    `SMC_ASSERT_NEXT(a_text_clears, i_clk, i_rst_n, w_accept && i_end_of_text, (r_count == '0) && !r_found && (w_bits == '0), "state not cleared after end of text")
    `SMC_ASSERT_NOW(a_empty_no_hit, i_clk, i_rst_n, r_len == '0, !w_hit && (w_bits == '0), "empty pattern produced a partial match")

endmodule

@@ hdl/smc_cell.sv @@
// ----------------------------------------------------------------------------
// smc_cell
// One pattern position: holds whether the pattern prefix ending here matched
// at the previous byte and extends it from the neighbor cell.
// ----------------------------------------------------------------------------
module smc_cell
    import smc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctrl        i_ctrl,
    input  logic              i_prev,
    input  logic              i_enable,
    input  logic [BYTE_W-1:0] i_pattern_byte,
    output logic              o_bit,
    output logic              o_next
);

    logic r_bit;
    logic n_bit;

    always_comb begin
        o_next = i_prev && i_enable && (i_ctrl.text_byte == i_pattern_byte);
        n_bit  = i_ctrl.clear ? 1'b0 : o_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_ctrl.step) begin
            r_bit <= n_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

@@ hdl/smc_out_queue.sv @@
// ----------------------------------------------------------------------------
// smc_out_queue
// Two-entry result queue between the cell row and the output channel.
// ----------------------------------------------------------------------------
module smc_out_queue
    import smc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push_valid,
    output logic    o_push_ready,
    input  t_result i_data,
    output logic    o_pop_valid,
    input  logic    i_pop_ready,
    output t_result o_data
);

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic [1:0] w_slot;
    logic       w_push;
    logic       w_pop;
    t_result    r_q0;
    t_result    r_q1;
    t_result    n_q0;
    t_result    n_q1;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_data       = r_q0;
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign w_slot       = r_cnt - {1'b0, w_pop};

    always_comb begin
        n_q0  = r_q0;
        n_q1  = r_q1;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        if (w_pop) begin
            n_q0 = r_q1;
        end
        if (w_push) begin
            if (w_slot == 2'd0) begin
                n_q0 = i_data;
            end else begin
                n_q1 = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

endmodule
